// ===== design/fsqs_pkg.sv =====
`default_nettype none
package fsqs_pkg;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned ETYPE_W   = 16;
  localparam int unsigned PROTO_W   = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned QUEUE_W   = 6;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned RANK_W    = 2;

  // highest queue that a 6-bit entry_queue can name, plus one
  localparam int unsigned MAX_QUEUES = 1 << QUEUE_W;

  localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  localparam logic DEV_STATE_INTERNAL_ERROR = 1'b1;

  localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_ADDR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET_PORT = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUT_MISS    = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_EXACT   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_ADDR    = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_PORT    = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FAILED  = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_WRITTEN = 3'd5;

  // match class, larger is higher priority
  localparam logic [RANK_W-1:0] RANK_NONE  = 2'd0;
  localparam logic [RANK_W-1:0] RANK_PORT  = 2'd1;
  localparam logic [RANK_W-1:0] RANK_ADDR  = 2'd2;
  localparam logic [RANK_W-1:0] RANK_EXACT = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } key_t;

  typedef struct packed {
    logic               set_addr;
    logic               set_port;
    logic [QUEUE_W-1:0] queue;
    key_t               data;
  } wr_t;

  typedef struct packed {
    logic               tok;
    logic [RANK_W-1:0]  rank;
    logic [QUEUE_W-1:0] queue;
  } link_t;

endpackage
`default_nettype wire

// ===== design/fsqs_cell.sv =====
`default_nettype none
module fsqs_cell import fsqs_pkg::*; #(
  parameter logic [QUEUE_W-1:0] IDX = '0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire wr_t   wr,
  input  wire key_t  key,
  input  wire link_t link_in,
  output link_t      link_out
);

  logic [ADDR_W-1:0] ra_r, ra_nxt;
  logic [PORT_W-1:0] rp_r, rp_nxt;
  link_t             link_r, link_nxt;
  logic              active;
  logic [RANK_W-1:0] cand;

  always_comb begin
    ra_nxt = ra_r;
    rp_nxt = rp_r;
    if (wr.queue == IDX) begin
      if (wr.set_addr) ra_nxt = wr.data.addr;
      if (wr.set_port) rp_nxt = wr.data.port;
    end
  end

  always_comb begin
    active = (ra_r != '0) || (rp_r != '0);
    cand   = RANK_NONE;
    if (active) begin
      if (ra_r == key.addr && rp_r == key.port) begin
        cand = RANK_EXACT;
      end else if (ra_r == key.addr && rp_r == '0) begin
        cand = RANK_ADDR;
      end else if (rp_r == key.port && ra_r == '0) begin
        cand = RANK_PORT;
      end
    end
  end

  // lower cells already won their class, so only a strictly better class takes over
  always_comb begin
    link_nxt = link_in;
    if (link_in.tok && cand > link_in.rank) begin
      link_nxt.rank  = cand;
      link_nxt.queue = IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_r       <= '0;
      rp_r       <= '0;
      link_r.tok <= 1'b0;
    end else begin
      ra_r       <= ra_nxt;
      rp_r       <= rp_nxt;
      link_r.tok <= link_nxt.tok;
    end
    link_r.rank  <= link_nxt.rank;
    link_r.queue <= link_nxt.queue;
  end

  assign link_out = link_r;

endmodule
`default_nettype wire

// ===== design/flow_steering_queue_select_unit.sv =====
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | req_type ether_type l4_protocol dest_address
//         |           |                       | dest_port entry_queue
// out     | output    | out_valid / out_ready | outcome queue_number
// cfg     | input     | cfg_valid / cfg_ready | data (device_failed)
//
// writes, failed-device lookups, unused request types and packets other than IPv4 TCP/UDP
// answer in the cycle after transfer; a steered lookup walks NCELL = min(NUM_QUEUES, 64)
// cells, one queue per cycle, into the result register; no new item is taken until it ends
// synchronous active-low reset clears all rules and the failed flag
// a stalled result holds; the next item is taken in the cycle the result transfers
module flow_steering_queue_select_unit import fsqs_pkg::*; #(
  parameter int unsigned NUM_QUEUES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [ETYPE_W-1:0]   in_ether_type,
  input  wire logic [PROTO_W-1:0]   in_l4_protocol,
  input  wire logic [ADDR_W-1:0]    in_dest_address,
  input  wire logic [PORT_W-1:0]    in_dest_port,
  input  wire logic [QUEUE_W-1:0]   in_entry_queue,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUTCOME_W-1:0]      out_outcome,
  output logic [QUEUE_W-1:0]        out_queue_number,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);

  // queues past the 6-bit field can never be written, so they get no cell
  localparam int unsigned NCELL = (NUM_QUEUES < MAX_QUEUES) ? NUM_QUEUES : MAX_QUEUES;

  logic                  failed_r, failed_nxt;
  logic                  busy_r, busy_nxt;
  logic                  start_r, start_nxt;
  key_t                  key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0]  out_outcome_r, out_outcome_nxt;
  logic [QUEUE_W-1:0]    out_queue_r, out_queue_nxt;

  logic                  accept;
  logic                  pkt_ok;
  logic                  to_chain;
  logic [OUTCOME_W-1:0]  imm_outcome;
  logic                  done;
  wr_t                   wr;
  link_t                 lnk [NCELL+1];
  logic [NCELL-1:0]      toks;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;

  assign pkt_ok = (in_ether_type == ETYPE_IPV4) &&
                  ((in_l4_protocol == PROTO_TCP) || (in_l4_protocol == PROTO_UDP));
  assign to_chain = (in_req_type == REQ_LOOKUP) && (failed_r != DEV_STATE_INTERNAL_ERROR)
                    && pkt_ok;

  always_comb begin
    case (in_req_type)
      REQ_SET_ADDR, REQ_SET_PORT: imm_outcome = OUT_WRITTEN;
      REQ_LOOKUP: begin
        imm_outcome = (failed_r == DEV_STATE_INTERNAL_ERROR) ? OUT_FAILED : OUT_MISS;
      end
      default:    imm_outcome = OUT_MISS;
    endcase
  end

  always_comb begin
    wr.set_addr  = accept && (in_req_type == REQ_SET_ADDR);
    wr.set_port  = accept && (in_req_type == REQ_SET_PORT);
    wr.queue     = in_entry_queue;
    wr.data.addr = in_dest_address;
    wr.data.port = in_dest_port;
  end

  assign lnk[0] = {start_r, RANK_NONE, {QUEUE_W{1'b0}}};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam logic [QUEUE_W-1:0] QI = QUEUE_W'(i);
    fsqs_cell #(.IDX(QI)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr),
      .key      (key_r),
      .link_in  (lnk[i]),
      .link_out (lnk[i+1])
    );
    assign toks[i] = lnk[i+1].tok;
  end

  assign done = lnk[NCELL].tok;

  always_comb begin
    failed_nxt      = failed_r;
    busy_nxt        = busy_r;
    start_nxt       = 1'b0;
    key_nxt         = key_r;
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    out_queue_nxt   = out_queue_r;

    if (cfg_valid && cfg_ready) failed_nxt = cfg_data;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (accept) begin
      if (to_chain) begin
        busy_nxt     = 1'b1;
        start_nxt    = 1'b1;
        key_nxt.addr = in_dest_address;
        key_nxt.port = in_dest_port;
      end else begin
        out_valid_nxt   = 1'b1;
        out_outcome_nxt = imm_outcome;
        out_queue_nxt   = '0;
      end
    end

    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_queue_nxt = lnk[NCELL].queue;
      case (lnk[NCELL].rank)
        RANK_EXACT: out_outcome_nxt = OUT_EXACT;
        RANK_ADDR:  out_outcome_nxt = OUT_ADDR;
        RANK_PORT:  out_outcome_nxt = OUT_PORT;
        default: begin
          out_outcome_nxt = OUT_MISS;
          out_queue_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r    <= 1'b0;
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      failed_r    <= failed_nxt;
      busy_r      <= busy_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r         <= key_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_queue_r   <= out_queue_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_queue_number = out_queue_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({toks, start_r}))
    else $error("more than one lookup token in the cell row");

  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || toks != '0) |-> busy_r)
    else $error("lookup token present while not busy");

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (!out_valid_r && !in_ready))
    else $error("result or new transfer during a walk");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (out_valid_r && !busy_r))
    else $error("walk end did not present a result");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
  import fsqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NQ         = 64;
  localparam int unsigned MAX_CYCLES = 500000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [ETYPE_W-1:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [ETYPE_W-1:0] ether_type;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [QUEUE_W-1:0] entry_queue;
  } steer_req_t;

  typedef struct {
    logic [OUTCOME_W-1:0] outcome;
    logic [QUEUE_W-1:0]   queue;
  } steer_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [ETYPE_W-1:0] in_ether_type = '0;
  logic [PROTO_W-1:0] in_l4_protocol = '0;
  logic [ADDR_W-1:0] in_dest_address = '0;
  logic [PORT_W-1:0] in_dest_port = '0;
  logic [QUEUE_W-1:0] in_entry_queue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [QUEUE_W-1:0] out_queue_number;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // mirror of the steering table and the failed flag
  logic [ADDR_W-1:0] rule_addr_mirror [NQ];
  logic [PORT_W-1:0] rule_port_mirror [NQ];
  logic failed_mirror = 1'b0;

  steer_req_t request_backlog [$];
  steer_res_t steer_expect_q [$];
  logic [ADDR_W-1:0] addr_pool [8];
  logic [PORT_W-1:0] port_pool [8];
  bit steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  flow_steering_queue_select_unit #(.NUM_QUEUES(NQ)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_ether_type(in_ether_type),
    .in_l4_protocol(in_l4_protocol), .in_dest_address(in_dest_address),
    .in_dest_port(in_dest_port), .in_entry_queue(in_entry_queue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_outcome(out_outcome), .out_queue_number(out_queue_number),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // updates the mirror for writes and returns the steering decision
  function automatic steer_res_t steer_predict(steer_req_t r);
    steer_res_t res;
    logic [OUTCOME_W-1:0] cls;
    bit hit;
    bit found;
    res.outcome = OUT_MISS;
    res.queue = '0;
    found = 1'b0;
    if (r.req == REQ_SET_ADDR || r.req == REQ_SET_PORT) begin
      if (r.entry_queue < NQ) begin
        if (r.req == REQ_SET_ADDR) rule_addr_mirror[r.entry_queue] = r.addr;
        else rule_port_mirror[r.entry_queue] = r.port;
      end
      res.outcome = OUT_WRITTEN;
    end else if (r.req == REQ_LOOKUP) begin
      if (failed_mirror) begin
        res.outcome = OUT_FAILED;
      end else if (r.ether_type == ETYPE_IPV4 &&
                   (r.proto == PROTO_TCP || r.proto == PROTO_UDP)) begin
        cls = OUT_EXACT;
        while (!found && cls <= OUT_PORT) begin
          for (int q = 0; q < NQ && !found; q++) begin
            if (rule_addr_mirror[q] == '0 && rule_port_mirror[q] == '0) continue;
            if (cls == OUT_EXACT)
              hit = rule_addr_mirror[q] == r.addr && rule_port_mirror[q] == r.port;
            else if (cls == OUT_ADDR)
              hit = rule_addr_mirror[q] == r.addr && rule_port_mirror[q] == '0;
            else
              hit = rule_port_mirror[q] == r.port && rule_addr_mirror[q] == '0;
            if (hit) begin
              found = 1'b1;
              res.outcome = cls;
              res.queue = QUEUE_W'(q);
            end
          end
          cls = cls + 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic steer_req_t make_req(logic [REQ_W-1:0] req, logic [ETYPE_W-1:0] et,
                                          logic [PROTO_W-1:0] pr, logic [ADDR_W-1:0] a,
                                          logic [PORT_W-1:0] p, logic [QUEUE_W-1:0] q);
    steer_req_t r;
    r.req = req;
    r.ether_type = et;
    r.proto = pr;
    r.addr = a;
    r.port = p;
    r.entry_queue = q;
    return r;
  endfunction

  // mostly writes and clean lookups drawn from small pools so rules get hit
  function automatic steer_req_t random_req();
    steer_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.req = REQ_LOOKUP;
    r.ether_type = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETYPE_IPV4;
    r.proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
    r.addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
    r.port = ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
    r.entry_queue = QUEUE_W'($urandom);
    if (pick < 35) begin
      r.req = ($urandom_range(0, 1) == 0) ? REQ_SET_ADDR : REQ_SET_PORT;
      if ($urandom_range(0, 3) == 0) r.entry_queue = QUEUE_W'($urandom_range(0, 7));
    end else if (pick < 90) begin
      r.req = REQ_LOOKUP;
    end else if (pick < 97) begin
      r.req = REQ_LOOKUP;
      r.ether_type = 16'($urandom);
      r.proto = 8'($urandom);
    end else begin
      r.req = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic queue_random(input int unsigned n);
    for (int i = 0; i < n; i++) request_backlog.push_back(random_req());
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_valid || steer_expect_q.size() != 0);
  endtask

  task automatic set_device_failed(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    failed_mirror = v;
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    steer_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        steer_expect_q.push_back(steer_predict(make_req(in_req_type, in_ether_type,
          in_l4_protocol, in_dest_address, in_dest_port, in_entry_queue)));
      if (!in_valid || in_ready) begin
        if (request_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 28)) begin
          r = request_backlog.pop_front();
          in_req_type <= r.req;
          in_ether_type <= r.ether_type;
          in_l4_protocol <= r.proto;
          in_dest_address <= r.addr;
          in_dest_port <= r.port;
          in_entry_queue <= r.entry_queue;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    steer_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (steer_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: outcome %0d queue %0d",
                     out_outcome, out_queue_number);
        end else begin
          want = steer_expect_q.pop_front();
          if (out_outcome !== want.outcome || out_queue_number !== want.queue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected outcome %0d queue %0d, got outcome %0d queue %0d",
                       want.outcome, want.queue, out_outcome, out_queue_number);
          end
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= 28;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] a1;
    logic [PORT_W-1:0] p1;
    a1 = 32'hC0A8_0101;
    p1 = 16'd443;
    for (int q = 0; q < NQ; q++) begin
      rule_addr_mirror[q] = '0;
      rule_port_mirror[q] = '0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = a1;
    for (int i = 3; i < 8; i++) addr_pool[i] = $urandom;
    port_pool[0] = '0;
    port_pool[1] = '1;
    port_pool[2] = p1;
    for (int i = 3; i < 8; i++) port_pool[i] = 16'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_device_failed(1'b0);

    // empty table, then extremes, every match class, ties and rejects
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_TCP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_SET_ADDR, '0, '0, '1, '0, '0));
    request_backlog.push_back(make_req(REQ_SET_PORT, '1, '1, '0, '1, '0));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_UDP, '1, '1, '1));
    request_backlog.push_back(make_req(REQ_SET_ADDR, ETYPE_IPV4, '0, a1, '0, 6'd63));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_TCP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_SET_PORT, '0, '0, '0, p1, 6'd5));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0001,
                                       p1, '0));
    request_backlog.push_back(make_req(REQ_SET_ADDR, '0, '0, a1, '0, 6'd20));
    request_backlog.push_back(make_req(REQ_SET_PORT, '0, '0, '0, p1, 6'd20));
    request_backlog.push_back(make_req(REQ_SET_ADDR, '0, '0, a1, '0, 6'd9));
    request_backlog.push_back(make_req(REQ_SET_PORT, '0, '0, '0, p1, 6'd9));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_UDP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV6, PROTO_TCP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_ICMP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_UNUSED, ETYPE_IPV4, PROTO_TCP, a1, p1, 6'd3));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_TCP, '0, '0, '0));
    // clearing the port turns the port-only rule back into an inactive one
    request_backlog.push_back(make_req(REQ_SET_PORT, '0, '0, '0, '0, 6'd5));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0001,
                                       p1, '0));
    request_backlog.push_back(make_req(REQ_SET_ADDR, '0, '0, '0, '0, '0));
    request_backlog.push_back(make_req(REQ_SET_PORT, '0, '0, '0, '0, '0));
    drain_all();

    // failed device: lookups short out, writes still land
    set_device_failed(1'b1);
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV4, PROTO_TCP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_SET_ADDR, '0, '0, a1, '0, 6'd1));
    request_backlog.push_back(make_req(REQ_LOOKUP, ETYPE_IPV6, PROTO_ICMP, a1, p1, '0));
    request_backlog.push_back(make_req(REQ_UNUSED, '0, '0, '0, '0, '0));
    queue_random(60);
    drain_all();

    set_device_failed(1'b0);
    steady = 1'b1;
    queue_random(250);
    drain_all();
    steady = 1'b0;
    queue_random(200);
    drain_all();
    set_device_failed(1'b1);
    queue_random(40);
    drain_all();
    set_device_failed(1'b0);
    queue_random(100);
    drain_all();

    repeat (NQ + 4) @(posedge clk);
    if (mismatches == 0 && steer_expect_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/fsqs_pkg.sv
design/fsqs_cell.sv
design/flow_steering_queue_select_unit.sv
sim/tb.sv
